>>> rtl/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker
package frt_pkg;

    // fragment header action codes
    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_DROP  = 2'd2;

    // one fragment header request
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] seq_index;
        logic [31:0] group_id;
        logic [63:0] key_id;
        logic [15:0] key_len;
        logic [31:0] msg_len;
        logic [31:0] lifetime;
        logic [15:0] frag_len;
    } frt_req_t;

    // one result
    typedef struct packed {
        logic        accepted;
        logic [31:0] write_offset;
        logic [31:0] reserved_total;
        logic        complete;
        logic [31:0] lifetime_out;
    } frt_rsp_t;

    // reassembly record
    typedef struct packed {
        logic        active;
        logic [31:0] stored_group;
        logic [63:0] stored_key;
        logic [31:0] expected_index;
        logic [31:0] stored_msg_len;
        logic [31:0] gathered_bytes;
        logic [15:0] stored_key_len;
        logic [31:0] stored_lifetime;
    } frt_record_t;

    // handshake status between the stages
    typedef struct packed {
        logic valid;
        logic advance;
    } frt_stage_ctl_t;

endpackage

>>> rtl/frt_ifs.sv
// Request and result channel interfaces of the fragment reassembly tracker

interface frt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] seq_index;
    logic [31:0] group_id;
    logic [63:0] key_id;
    logic [15:0] key_len;
    logic [31:0] msg_len;
    logic [31:0] lifetime;
    logic [15:0] frag_len;

    modport source (
        output valid, action, seq_index, group_id, key_id, key_len, msg_len,
               lifetime, frag_len,
        input  ready
    );
    modport sink (
        input  valid, action, seq_index, group_id, key_id, key_len, msg_len,
               lifetime, frag_len,
        output ready
    );
endinterface

interface frt_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] write_offset;
    logic [31:0] reserved_total;
    logic        complete;
    logic [31:0] lifetime_out;

    modport source (
        output valid, accepted, write_offset, reserved_total, complete, lifetime_out,
        input  ready
    );
    modport sink (
        input  valid, accepted, write_offset, reserved_total, complete, lifetime_out,
        output ready
    );
endinterface

>>> rtl/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker
//
// Follows the reassembly of one keyed message that arrives as numbered
// fragments. Each header request (begin, take or drop) yields exactly one
// result: whether the fragment was accepted, the buffer offset for its payload,
// the buffer size to reserve on a begin, the completion flag and the stored
// lifetime. A request passes an input register, is checked against the record
// combinationally, and lands in a result register, so one request is taken every
// cycle while results are read. Its result is offered once the request has moved
// from the input register on into the result register. The input register still
// takes one request while the result register holds an unread result; the
// request side stalls only once both registers are full and the result is not
// being read.
module fragment_reassembly_tracker (
    input  logic      clk,
    input  logic      rst_n,
    frt_req_if.sink   req,
    frt_rsp_if.source rsp
);

    frt_pkg::frt_stage_ctl_t in_ctl;
    frt_pkg::frt_req_t       in_data;
    frt_pkg::frt_rsp_t       result;
    logic                    advance;

    // header request register
    frt_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .ctl     (in_ctl),
        .data    (in_data)
    );

    // record and checks
    frt_check u_check (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (in_ctl),
        .data   (in_data),
        .result (result)
    );

    // result register
    frt_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ctl.valid),
        .result   (result),
        .advance  (advance),
        .rsp      (rsp)
    );

endmodule

>>> rtl/frt_in_stage.sv
// Input register stage holding one accepted fragment header request
module frt_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    frt_req_if.sink          req,
    input  logic             advance,
    output frt_pkg::frt_stage_ctl_t ctl,
    output frt_pkg::frt_req_t data
);

    logic              valid_reg;
    logic              valid_next;
    frt_pkg::frt_req_t data_reg;
    logic              load;

    // take a request when empty or when the held one moves on
    assign req.ready = !valid_reg || advance;
    assign load      = req.valid && req.ready;

    // occupancy
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.action    <= req.action;
            data_reg.seq_index <= req.seq_index;
            data_reg.group_id  <= req.group_id;
            data_reg.key_id    <= req.key_id;
            data_reg.key_len   <= req.key_len;
            data_reg.msg_len   <= req.msg_len;
            data_reg.lifetime  <= req.lifetime;
            data_reg.frag_len  <= req.frag_len;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign data        = data_reg;

endmodule

>>> rtl/frt_check.sv
// Reassembly record and the per-fragment acceptance checks
module frt_check (
    input  logic              clk,
    input  logic              rst_n,
    input  frt_pkg::frt_stage_ctl_t ctl,
    input  frt_pkg::frt_req_t data,
    output frt_pkg::frt_rsp_t result
);

    frt_pkg::frt_record_t rec_reg;
    frt_pkg::frt_record_t rec_next;
    logic                 fire;
    logic [32:0]          total;
    logic [15:0]          trail_len;
    logic                 begin_ok;
    logic [31:0]          space_left;
    logic                 take_ok;

    assign fire = ctl.valid && ctl.advance;

    // begin checks: first index, key fits, body fits, total fits 32 bits
    assign total     = {17'd0, data.key_len} + {1'b0, data.msg_len};
    assign trail_len = data.frag_len - data.key_len;
    assign begin_ok  = (data.seq_index == 32'd0) && (data.key_len != 16'd0) &&
                       (data.frag_len >= data.key_len) &&
                       ({16'd0, trail_len} <= data.msg_len) && !total[32];

    // take checks against the stored record
    assign space_left = rec_reg.stored_msg_len - rec_reg.gathered_bytes;
    assign take_ok    = rec_reg.active && (data.group_id == rec_reg.stored_group) &&
                        (data.key_id == rec_reg.stored_key) &&
                        (data.seq_index == rec_reg.expected_index) &&
                        (data.msg_len == rec_reg.stored_msg_len) &&
                        (data.frag_len != 16'd0) &&
                        ({16'd0, data.frag_len} <= space_left);

    // next record and result
    always_comb
    begin
        rec_next              = rec_reg;
        result.accepted       = 1'b0;
        result.write_offset   = 32'd0;
        result.reserved_total = 32'd0;
        case (data.action)
            frt_pkg::ACT_BEGIN:
            begin
                if (begin_ok)
                begin
                    rec_next.active          = 1'b1;
                    rec_next.stored_group    = data.group_id;
                    rec_next.stored_key      = data.key_id;
                    rec_next.expected_index  = 32'd1;
                    rec_next.stored_msg_len  = data.msg_len;
                    rec_next.gathered_bytes  = {16'd0, trail_len};
                    rec_next.stored_key_len  = data.key_len;
                    rec_next.stored_lifetime = data.lifetime;
                    result.accepted          = 1'b1;
                    result.reserved_total    = total[31:0];
                end
            end
            frt_pkg::ACT_TAKE:
            begin
                if (take_ok)
                begin
                    result.write_offset     = {16'd0, rec_reg.stored_key_len} +
                                              rec_reg.gathered_bytes;
                    rec_next.gathered_bytes = rec_reg.gathered_bytes +
                                              {16'd0, data.frag_len};
                    rec_next.expected_index = rec_reg.expected_index + 32'd1;
                    result.accepted         = 1'b1;
                end
            end
            frt_pkg::ACT_DROP:
            begin
                rec_next = '0;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
        result.complete     = rec_next.active &&
                              (rec_next.gathered_bytes == rec_next.stored_msg_len);
        result.lifetime_out = rec_next.stored_lifetime;
    end

    // record update once the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else if (fire)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

>>> rtl/frt_out_stage.sv
// Result register stage driving the result channel
module frt_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  frt_pkg::frt_rsp_t result,
    output logic              advance,
    frt_rsp_if.source         rsp
);

    logic              valid_reg;
    logic              valid_next;
    frt_pkg::frt_rsp_t data_reg;
    logic              load;

    // room when empty or when the held result is taken this cycle
    assign advance = !valid_reg || rsp.ready;
    assign load    = in_valid && advance;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.accepted       = data_reg.accepted;
    assign rsp.write_offset   = data_reg.write_offset;
    assign rsp.reserved_total = data_reg.reserved_total;
    assign rsp.complete       = data_reg.complete;
    assign rsp.lifetime_out   = data_reg.lifetime_out;

endmodule

>>> tb/sv/frt_board_pkg.sv
// Scoreboard class for the fragment reassembly tracker testbench
`timescale 1ns / 1ps

package frt_board_pkg;

    import frt_pkg::*;

    // action code the block ignores
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    class reassembly_board;

        frt_record_t record;
        frt_rsp_t    pending_results[$];
        int          errors;

        function new();
            record = '0;
            errors = 0;
        endfunction

        // work out the result of one header and advance the record
        function frt_rsp_t predict_header(frt_req_t h);
            frt_rsp_t    res;
            logic [32:0] total;
            logic [31:0] body;
            res   = '0;
            total = {17'd0, h.key_len} + {1'b0, h.msg_len};
            body  = {16'd0, h.frag_len} - {16'd0, h.key_len};
            case (h.action)
                ACT_BEGIN:
                begin
                    if (h.seq_index == 32'd0 && h.key_len != 16'd0 &&
                        h.frag_len >= h.key_len && body <= h.msg_len && !total[32])
                    begin
                        record.active          = 1'b1;
                        record.stored_group    = h.group_id;
                        record.stored_key      = h.key_id;
                        record.expected_index  = 32'd1;
                        record.stored_msg_len  = h.msg_len;
                        record.gathered_bytes  = body;
                        record.stored_key_len  = h.key_len;
                        record.stored_lifetime = h.lifetime;
                        res.accepted           = 1'b1;
                        res.reserved_total     = total[31:0];
                    end
                end
                ACT_TAKE:
                begin
                    if (record.active && h.group_id == record.stored_group &&
                        h.key_id == record.stored_key &&
                        h.seq_index == record.expected_index &&
                        h.msg_len == record.stored_msg_len && h.frag_len != 16'd0 &&
                        {16'd0, h.frag_len} <= record.stored_msg_len - record.gathered_bytes)
                    begin
                        res.write_offset      = {16'd0, record.stored_key_len} +
                                                record.gathered_bytes;
                        record.gathered_bytes = record.gathered_bytes + {16'd0, h.frag_len};
                        record.expected_index = record.expected_index + 32'd1;
                        res.accepted          = 1'b1;
                    end
                end
                ACT_DROP:
                begin
                    record = '0;
                end
                default:
                begin
                end
            endcase
            res.complete     = record.active &&
                               (record.gathered_bytes == record.stored_msg_len);
            res.lifetime_out = record.stored_lifetime;
            return res;
        endfunction

        // accepted header request: queue its expected result
        function void take_header(frt_req_t h);
            pending_results.push_back(predict_header(h));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // compare one result with the oldest expectation
        task check_result(frt_rsp_t got);
            frt_rsp_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted)
                report_mismatch($sformatf("accepted got %0b want %0b",
                                          got.accepted, want.accepted));
            if (got.write_offset !== want.write_offset)
                report_mismatch($sformatf("write_offset got %0h want %0h",
                                          got.write_offset, want.write_offset));
            if (got.reserved_total !== want.reserved_total)
                report_mismatch($sformatf("reserved_total got %0h want %0h",
                                          got.reserved_total, want.reserved_total));
            if (got.complete !== want.complete)
                report_mismatch($sformatf("complete got %0b want %0b",
                                          got.complete, want.complete));
            if (got.lifetime_out !== want.lifetime_out)
                report_mismatch($sformatf("lifetime_out got %0h want %0h",
                                          got.lifetime_out, want.lifetime_out));
        endtask

    endclass

endpackage

>>> tb/sv/tb_fragment_reassembly_tracker.sv
// Top level testbench of the fragment reassembly tracker
`timescale 1ns / 1ps

module tb_fragment_reassembly_tracker;

    import frt_pkg::*;
    import frt_board_pkg::*;

    localparam int          RSP_HOLD_CYCLES = 60;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    logic clk;
    logic rst_n;

    frt_req_if req_ch();
    frt_rsp_if rsp_ch();

    reassembly_board board;

    int          snd_idle_pct;
    int          rsp_idle_pct;
    bit          hold_rsp;
    int          hold_count;
    int          sent_count;
    int unsigned cycle_count;

    fragment_reassembly_tracker i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_fragment_reassembly_tracker: FAIL");
            $finish;
        end
    end

    // watch both channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                board.take_header(frt_req_t'{
                    action:    req_ch.action,
                    seq_index: req_ch.seq_index,
                    group_id:  req_ch.group_id,
                    key_id:    req_ch.key_id,
                    key_len:   req_ch.key_len,
                    msg_len:   req_ch.msg_len,
                    lifetime:  req_ch.lifetime,
                    frag_len:  req_ch.frag_len});
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result(frt_rsp_t'{
                    accepted:       rsp_ch.accepted,
                    write_offset:   rsp_ch.write_offset,
                    reserved_total: rsp_ch.reserved_total,
                    complete:       rsp_ch.complete,
                    lifetime_out:   rsp_ch.lifetime_out});
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < RSP_HOLD_CYCLES; hold_count++)
                    @(posedge clk);
                hold_rsp = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    function automatic frt_req_t make_header(logic [1:0] act, logic [31:0] seq,
                                             logic [31:0] grp, logic [63:0] key,
                                             logic [15:0] klen, logic [31:0] mlen,
                                             logic [31:0] life, logic [15:0] flen);
        frt_req_t h;
        h.action    = act;
        h.seq_index = seq;
        h.group_id  = grp;
        h.key_id    = key;
        h.key_len   = klen;
        h.msg_len   = mlen;
        h.lifetime  = life;
        h.frag_len  = flen;
        return h;
    endfunction

    // offer one header, with random gaps ahead of it, until it is taken
    task automatic send_header(input frt_req_t h);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= h.action;
        req_ch.seq_index <= h.seq_index;
        req_ch.group_id  <= h.group_id;
        req_ch.key_id    <= h.key_id;
        req_ch.key_len   <= h.key_len;
        req_ch.msg_len   <= h.msg_len;
        req_ch.lifetime  <= h.lifetime;
        req_ch.frag_len  <= h.frag_len;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        if (h.action != ACT_UNDEFINED)
            sent_count++;
    endtask

    // stop offering until every outstanding result has been read
    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed begin/take runs with random content, some noise
    task automatic run_random(input int n_items);
        frt_req_t    h;
        logic [31:0] g, mlen, life, idx;
        logic [63:0] k;
        logic [15:0] klen, flen;
        longint      gathered, remaining, room, cap;
        bit          begin_ok, corrupt;
        int          ntake, t, target, sel;
        target = sent_count + n_items;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                g    = $urandom;
                k    = {$urandom, $urandom};
                life = $urandom;
                klen = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535)
                                                       : $urandom_range(1, 32));
                sel  = $urandom_range(0, 9);
                if (sel < 8)
                    mlen = $urandom_range(0, 3000);
                else if (sel == 8)
                    mlen = $urandom;
                else
                    mlen = 32'hFFFF_FFFF - {16'd0, klen} + $urandom_range(0, 1);
                begin_ok = (longint'(klen) + longint'(mlen)) <= 64'hFFFF_FFFF;
                room     = 65535 - longint'(klen);
                cap      = (longint'(mlen) < room) ? longint'(mlen) : room;
                gathered = longint'($urandom_range(0, int'(cap)));
                send_header(make_header(ACT_BEGIN, 32'd0, g, k, klen, mlen, life,
                                        klen + 16'(gathered)));
                idx   = 32'd1;
                ntake = $urandom_range(0, 10);
                for (t = 0; t < ntake; t++)
                begin
                    remaining = longint'(mlen) - gathered;
                    cap       = (remaining < 65535) ? remaining : 65535;
                    if (remaining == 0)
                        flen = 16'($urandom_range(1, 65535));
                    else if ($urandom_range(0, 3) == 0 && remaining <= 65535)
                        flen = 16'(remaining);
                    else
                        flen = 16'($urandom_range(1, int'(cap)));
                    h = make_header(ACT_TAKE, idx, g, k, 16'($urandom_range(0, 65535)),
                                    mlen, $urandom, flen);
                    corrupt = ($urandom_range(0, 19) == 0);
                    if (corrupt)
                    begin
                        case ($urandom_range(0, 5))
                            0: h.group_id  = h.group_id ^ (32'd1 << $urandom_range(0, 31));
                            1: h.key_id    = h.key_id ^ (64'd1 << $urandom_range(0, 63));
                            2: h.seq_index = h.seq_index + $urandom_range(1, 3);
                            3: h.msg_len   = h.msg_len ^ (32'd1 << $urandom_range(0, 31));
                            4: h.frag_len  = 16'd0;
                            default: h.frag_len = (remaining < 65535) ? 16'(remaining + 1)
                                                                      : 16'd0;
                        endcase
                    end
                    send_header(h);
                    if (begin_ok && !corrupt && remaining != 0)
                    begin
                        gathered = gathered + longint'(flen);
                        idx      = idx + 32'd1;
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    send_header(make_header(ACT_DROP, $urandom, $urandom,
                                            {$urandom, $urandom},
                                            16'($urandom_range(0, 65535)),
                                            $urandom, $urandom,
                                            16'($urandom_range(0, 65535))));
            end
            else
            begin
                // fully random header
                send_header(make_header(2'($urandom_range(0, 3)),
                                        ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom,
                                        $urandom, {$urandom, $urandom},
                                        16'($urandom_range(0, 65535)), $urandom, $urandom,
                                        16'($urandom_range(0, 65535))));
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [31:0] grp_a;
        logic [63:0] key_a;
        board        = new();
        grp_a        = 32'h1234_5678;
        key_a        = 64'h0BAD_F00D_DEAD_BEEF;
        cycle_count  = 0;
        sent_count   = 0;
        hold_rsp     = 1'b0;
        snd_idle_pct = 18;
        rsp_idle_pct = 65;
        rst_n        = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_BEGIN;
        req_ch.seq_index = '0;
        req_ch.group_id  = '0;
        req_ch.key_id    = '0;
        req_ch.key_len   = '0;
        req_ch.msg_len   = '0;
        req_ch.lifetime  = '0;
        req_ch.frag_len  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing active yet: take, drop and the ignored code
        send_header(make_header(ACT_TAKE, 32'd1, grp_a, key_a, 16'd0, 32'd100, 32'd0, 16'd10));
        send_header(make_header(ACT_DROP, 32'd0, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 16'd0));
        send_header(make_header(ACT_UNDEFINED, 32'd0, grp_a, key_a, 16'd8, 32'd100,
                                32'd7, 16'd8));
        // begins that fail each check
        send_header(make_header(ACT_BEGIN, 32'd1, grp_a, key_a, 16'd8, 32'd100, 32'd7, 16'd8));
        send_header(make_header(ACT_BEGIN, 32'd0, grp_a, key_a, 16'd0, 32'd100, 32'd7, 16'd8));
        send_header(make_header(ACT_BEGIN, 32'd0, grp_a, key_a, 16'd8, 32'd100, 32'd7, 16'd4));
        send_header(make_header(ACT_BEGIN, 32'd0, grp_a, key_a, 16'd8, 32'd10, 32'd7, 16'd19));
        send_header(make_header(ACT_BEGIN, 32'd0, grp_a, key_a, 16'hFFFF, 32'hFFFF_FFFF,
                                32'd7, 16'hFFFF));
        // total exactly at the 32-bit limit
        send_header(make_header(ACT_BEGIN, 32'd0, 32'd0, 64'd0, 16'd1, 32'hFFFF_FFFE,
                                32'd0, 16'd1));
        // accepted begin replaces the active record
        send_header(make_header(ACT_BEGIN, 32'd0, grp_a, key_a, 16'd8, 32'd100,
                                32'hCAFE_0001, 16'd48));
        // takes that must be refused
        send_header(make_header(ACT_TAKE, 32'd1, grp_a, key_a, 16'd0, 32'd100, 32'd0, 16'd0));
        send_header(make_header(ACT_TAKE, 32'd1, ~grp_a, key_a, 16'd0, 32'd100, 32'd0, 16'd5));
        send_header(make_header(ACT_TAKE, 32'd1, grp_a, ~key_a, 16'd0, 32'd100, 32'd0, 16'd5));
        send_header(make_header(ACT_TAKE, 32'd2, grp_a, key_a, 16'd0, 32'd100, 32'd0, 16'd5));
        send_header(make_header(ACT_TAKE, 32'd1, grp_a, key_a, 16'd0, 32'd101, 32'd0, 16'd5));
        send_header(make_header(ACT_TAKE, 32'd1, grp_a, key_a, 16'd0, 32'd100, 32'd0, 16'd61));
        // exact fill completes the message
        send_header(make_header(ACT_TAKE, 32'd1, grp_a, key_a, 16'd0, 32'd100, 32'd0, 16'd60));
        send_header(make_header(ACT_UNDEFINED, $urandom, $urandom, {$urandom, $urandom},
                                16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        // rejected begin leaves the active record alone
        send_header(make_header(ACT_BEGIN, 32'd5, grp_a, key_a, 16'd8, 32'd100, 32'd9, 16'd8));
        // all-ones fields, empty body, complete at once
        send_header(make_header(ACT_BEGIN, 32'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF));
        send_header(make_header(ACT_DROP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 16'hFFFF));
        // largest key and body, then a full-size take
        send_header(make_header(ACT_BEGIN, 32'd0, 32'd0, 64'd0, 16'hFFFF, 32'hFFFF_0000,
                                32'd3, 16'hFFFF));
        send_header(make_header(ACT_TAKE, 32'd1, 32'd0, 64'd0, 16'd0, 32'hFFFF_0000,
                                32'd0, 16'hFFFF));
        send_header(make_header(ACT_DROP, 32'd0, 32'd0, 64'd0, 16'd0, 32'd0, 32'd0, 16'd0));

        // sender idles lightly, receiver heavily; long receiver hold-off midway
        run_random(120);
        hold_rsp = 1'b1;
        run_random(200);
        wait_results_drained();

        // roles swapped
        snd_idle_pct = 65;
        rsp_idle_pct = 18;
        run_random(315);

        // no idling on either side, with one more hold-off
        snd_idle_pct = 0;
        rsp_idle_pct = 0;
        run_random(150);
        hold_rsp = 1'b1;
        run_random(165);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("tb_fragment_reassembly_tracker: PASS");
        else
            $display("tb_fragment_reassembly_tracker: FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/frt_pkg.sv
rtl/frt_ifs.sv
rtl/frt_in_stage.sv
rtl/frt_check.sv
rtl/frt_out_stage.sv
rtl/fragment_reassembly_tracker.sv
tb/sv/frt_board_pkg.sv
tb/sv/tb_fragment_reassembly_tracker.sv
